// File: rtl/rgbc_pkg.sv
// Shared types and constants for the RGB 3x3 convolution filter.
// No dependencies; imported by every module of the block.
package rgbc_pkg;

    localparam int PIX_W           = 8;
    localparam int WEIGHT_W        = 18;
    localparam int KERNEL_W        = 3 * WEIGHT_W;
    localparam int CFG_W           = 12;
    localparam int TOT_W           = 2 * CFG_W;
    localparam int COEFF_FRAC_BITS = 6;
    localparam int OFFSET_VALUE    = 127;
    localparam int PIX_MAX         = 255;
    localparam int MIN_DIM         = 3;
    localparam int MAX_HEIGHT      = 2048;
    localparam int ROW_CNT_W       = 11;
    localparam int ROW_MAX         = 2047;
    localparam int PROD_W          = WEIGHT_W + PIX_W + 1;
    localparam int ROW_SUM_W       = PROD_W + 2;
    localparam int ACC_W           = ROW_SUM_W + 2;
    localparam int FIFO_DEPTH      = 8;
    localparam int FIFO_AW         = 3;
    localparam int FIFO_CW         = 4;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        REG_KERNEL_ABOVE  = 3'd0,
        REG_KERNEL_CENTER = 3'd1,
        REG_KERNEL_BELOW  = 3'd2,
        REG_OFFSET_ENABLE = 3'd3,
        REG_IMAGE_WIDTH   = 3'd4,
        REG_IMAGE_HEIGHT  = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pix_t;

    typedef struct packed {
        pix_t older;
        pix_t newer;
    } line_pair_t;

    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef weight_t [8:0] kernel_t;
    typedef logic [8:0][PIX_W-1:0] chan_win_t;

    typedef struct packed {
        logic emit;
        logic inner;
        logic last;
    } tag_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef struct packed {
        pix_t pix;
        logic last;
    } out_item_t;

endpackage

// File: rtl/rgbc_div.sv
// Bit-serial restoring divider: splits the output pixel count into row and column.
// Depends on rgbc_pkg.
module rgbc_div
    import rgbc_pkg::*;
#(
    parameter int DVD_W = 22
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DVD_W-1:0]   dividend,
    input  logic [CFG_W-1:0]   divisor,
    output div_status_t        status,
    output logic [DVD_W-1:0]   quotient,
    output logic [CFG_W-1:0]   remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [CFG_W-1:0] rem_reg;
    logic [CFG_W-1:0] dsr_reg;
    logic [CFG_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? CFG_W'(trial - {1'b0, dsr_reg}) : CFG_W'(trial);
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule

// File: rtl/rgbc_filter.sv
// One color channel of the 3x3 weighted sum: products, row sums, total, then
// truncation, offset and clamp. Depends on rgbc_pkg.
module rgbc_filter
    import rgbc_pkg::*;
(
    input  logic             clk,
    input  chan_win_t        win,
    input  kernel_t          kernel,
    input  logic             offset_en,
    output logic [PIX_W-1:0] result
);

    localparam int ADJ_W = ACC_W + 1;
    localparam logic signed [ADJ_W-1:0] RND   = ADJ_W'((1 << COEFF_FRAC_BITS) - 1);
    localparam logic signed [ADJ_W-1:0] OFFS  = ADJ_W'(OFFSET_VALUE);
    localparam logic signed [ADJ_W-1:0] SAT_HI = ADJ_W'(PIX_MAX);

    logic signed [PROD_W-1:0]    prod_reg [9];
    logic signed [ROW_SUM_W-1:0] row_reg  [3];
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ADJ_W-1:0]     acc_adj;
    logic signed [ADJ_W-1:0]     qo;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            prod_reg[i] <= $signed(kernel[i]) * $signed({1'b0, win[i]});
        end
        for (int r = 0; r < 3; r++)
        begin
            row_reg[r] <= ROW_SUM_W'(prod_reg[3*r]) + ROW_SUM_W'(prod_reg[3*r+1])
                        + ROW_SUM_W'(prod_reg[3*r+2]);
        end
        acc_reg <= ACC_W'(row_reg[0]) + ACC_W'(row_reg[1]) + ACC_W'(row_reg[2]);
    end

    always_comb
    begin
        acc_adj = ADJ_W'(acc_reg);
        if (acc_reg < 0)
        begin
            acc_adj = acc_adj + RND;
        end
        qo = acc_adj >>> COEFF_FRAC_BITS;
        if (offset_en)
        begin
            qo = qo + OFFS;
        end
        priority if (qo < 0)
        begin
            result = '0;
        end
        else if (qo > SAT_HI)
        begin
            result = PIX_W'(PIX_MAX);
        end
        else
        begin
            result = qo[PIX_W-1:0];
        end
    end

endmodule

// File: rtl/rgb_conv3x3_filter_unit.sv
// Streaming 3x3 RGB convolution: line memory, window, per-channel filters, output queue.
// Depends on rgbc_pkg, rgbc_div, rgbc_filter.
//
//  channel | signals                                        | handshake
//  cfg     | cfg_write, cfg_index, cfg_data                 | write when cfg_write high
//  in      | operation, in_red, in_green, in_blue           | in_valid / in_stall
//  out     | out_red, out_green, out_blue, frame_last       | out_valid / out_stall
//
// One request per cycle while in_stall is low; results queue after the filter pipeline.
// The line memory (one read and one write port) and an 8-entry output queue set the rate;
// in_stall rises when eight results are in flight or queued.
// A width write holds in_stall while the divider recomputes the output position;
// any config write holds it for one cycle.
// Reset clears control and counters; the line memory holds no reset value.
module rgb_conv3x3_filter_unit
    import rgbc_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [KERNEL_W-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                operation,
    input  logic [PIX_W-1:0]    in_red,
    input  logic [PIX_W-1:0]    in_green,
    input  logic [PIX_W-1:0]    in_blue,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [PIX_W-1:0]    out_red,
    output logic [PIX_W-1:0]    out_green,
    output logic [PIX_W-1:0]    out_blue,
    output logic                frame_last
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int OCW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int WCMP = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int CMPW = TOT_W + 1;

    logic [KERNEL_W-1:0]  k_above_reg;
    logic [KERNEL_W-1:0]  k_center_reg;
    logic [KERNEL_W-1:0]  k_below_reg;
    logic                 offset_en_reg;
    logic [CFG_W-1:0]     width_reg;
    logic [CFG_W-1:0]     height_reg;
    logic [CFG_W-1:0]     w_eff;
    logic [CFG_W-1:0]     h_eff;
    logic [CFG_W-1:0]     w_eff_reg;
    logic [CFG_W-1:0]     w_lim_reg;
    logic [CFG_W-1:0]     h_lim_reg;
    logic [TOT_W-1:0]     total_reg;
    logic                 cfg_hold_reg;
    logic                 div_start_reg;

    logic [CW-1:0]        col_reg;
    logic [CW-1:0]        col_next;
    logic [1:0]           in_row_reg;
    logic [1:0]           in_row_next;
    logic [OCW-1:0]       out_cnt_reg;
    logic [OCW-1:0]       out_cnt_next;
    logic [CW-1:0]        ocol_reg;
    logic [CW-1:0]        ocol_next;
    logic [ROW_CNT_W-1:0] orow_reg;
    logic [ROW_CNT_W-1:0] orow_next;

    logic                 accept;
    logic                 drain;
    logic                 primed;
    logic                 take;
    logic                 col_wrap;
    logic                 ocol_wrap;
    logic                 inner;
    logic                 last;
    pix_t                 pix_in;

    line_pair_t           line_mem [MAX_WIDTH];
    line_pair_t           rd_reg;
    logic                 a_valid_reg;
    tag_t                 a_tag_reg;
    logic [CW-1:0]        a_col_reg;
    pix_t                 a_pix_reg;
    tag_t                 b_tag_reg;
    tag_t                 c_tag_reg;
    tag_t                 d_tag_reg;
    tag_t                 e_tag_reg;
    pix_t                 c_center_reg;
    pix_t                 d_center_reg;
    pix_t                 e_center_reg;
    pix_t                 win_reg [3][3];

    logic [2:0][KERNEL_W-1:0] rows;
    kernel_t              kernel;
    chan_win_t            win_red;
    chan_win_t            win_green;
    chan_win_t            win_blue;
    logic [PIX_W-1:0]     filt_red;
    logic [PIX_W-1:0]     filt_green;
    logic [PIX_W-1:0]     filt_blue;

    out_item_t            fifo_mem [FIFO_DEPTH];
    out_item_t            push_item;
    logic [FIFO_AW-1:0]   fifo_head_reg;
    logic [FIFO_AW-1:0]   fifo_tail_reg;
    logic [FIFO_CW-1:0]   fifo_cnt_reg;
    logic [FIFO_CW-1:0]   pending_reg;
    logic                 push;
    logic                 pop;
    logic                 credit;

    div_status_t          div_st;
    logic [OCW-1:0]       div_quo;
    logic [CFG_W-1:0]     div_rem;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_above_reg   <= '0;
            k_center_reg  <= KERNEL_W'(64'd16777216);
            k_below_reg   <= '0;
            offset_en_reg <= 1'b0;
            width_reg     <= CFG_W'(640);
            height_reg    <= CFG_W'(480);
            cfg_hold_reg  <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            cfg_hold_reg  <= cfg_write;
            div_start_reg <= cfg_write && (cfg_index == REG_IMAGE_WIDTH);
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_KERNEL_ABOVE:  k_above_reg   <= cfg_data;
                    REG_KERNEL_CENTER: k_center_reg  <= cfg_data;
                    REG_KERNEL_BELOW:  k_below_reg   <= cfg_data;
                    REG_OFFSET_ENABLE: offset_en_reg <= cfg_data[0];
                    REG_IMAGE_WIDTH:   width_reg     <= cfg_data[CFG_W-1:0];
                    REG_IMAGE_HEIGHT:  height_reg    <= cfg_data[CFG_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    always_comb
    begin
        priority if (width_reg < CFG_W'(MIN_DIM))
        begin
            w_eff = CFG_W'(MIN_DIM);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            w_eff = CFG_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        priority if (height_reg < CFG_W'(MIN_DIM))
        begin
            h_eff = CFG_W'(MIN_DIM);
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        w_eff_reg <= w_eff;
        w_lim_reg <= w_eff - CFG_W'(2);
        h_lim_reg <= h_eff - CFG_W'(2);
        total_reg <= w_eff * h_eff;
    end

    rgbc_div #(
        .DVD_W (OCW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (out_cnt_reg),
        .divisor   (w_eff),
        .status    (div_st),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // request admission and position counters
    assign in_stall = (pending_reg == FIFO_CW'(FIFO_DEPTH)) || cfg_hold_reg || div_start_reg
                    || div_st.busy || div_st.done;
    assign accept   = in_valid && !in_stall;
    assign drain    = operation == OP_DRAIN;
    assign primed   = (in_row_reg >= 2'd2) || (in_row_reg == 2'd1 && col_reg != '0);
    assign take     = accept && !(drain && !primed);
    assign pix_in   = drain ? '0 : {in_red, in_green, in_blue};
    assign credit   = take && primed;

    assign col_wrap  = WCMP'(col_reg) + WCMP'(1) >= WCMP'(w_eff_reg);
    assign ocol_wrap = WCMP'(ocol_reg) + WCMP'(1) >= WCMP'(w_eff_reg);
    assign inner     = (orow_reg != '0) && (CFG_W'(orow_reg) <= h_lim_reg)
                    && (ocol_reg != '0) && (WCMP'(ocol_reg) <= WCMP'(w_lim_reg));
    assign last      = CMPW'(out_cnt_reg) + CMPW'(1) >= CMPW'(total_reg);

    always_comb
    begin
        col_next     = col_reg;
        in_row_next  = in_row_reg;
        out_cnt_next = out_cnt_reg;
        ocol_next    = ocol_reg;
        orow_next    = orow_reg;
        priority if (div_st.done)
        begin
            ocol_next = CW'(div_rem);
            orow_next = (int'(div_quo) > ROW_MAX) ? ROW_CNT_W'(ROW_MAX)
                                                  : ROW_CNT_W'(div_quo);
        end
        else if (take)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                if (in_row_reg != 2'd2)
                begin
                    in_row_next = in_row_reg + 2'd1;
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
            if (primed)
            begin
                if (last)
                begin
                    col_next     = '0;
                    in_row_next  = '0;
                    out_cnt_next = '0;
                    ocol_next    = '0;
                    orow_next    = '0;
                end
                else
                begin
                    out_cnt_next = out_cnt_reg + OCW'(1);
                    if (ocol_wrap)
                    begin
                        ocol_next = '0;
                        if (orow_reg != ROW_CNT_W'(ROW_MAX))
                        begin
                            orow_next = orow_reg + ROW_CNT_W'(1);
                        end
                    end
                    else
                    begin
                        ocol_next = ocol_reg + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            in_row_reg  <= '0;
            out_cnt_reg <= '0;
            ocol_reg    <= '0;
            orow_reg    <= '0;
            a_valid_reg <= 1'b0;
            a_tag_reg   <= '0;
            b_tag_reg   <= '0;
            c_tag_reg   <= '0;
            d_tag_reg   <= '0;
            e_tag_reg   <= '0;
        end
        else
        begin
            col_reg          <= col_next;
            in_row_reg       <= in_row_next;
            out_cnt_reg      <= out_cnt_next;
            ocol_reg         <= ocol_next;
            orow_reg         <= orow_next;
            a_valid_reg      <= take;
            a_tag_reg.emit   <= credit;
            a_tag_reg.inner  <= inner;
            a_tag_reg.last   <= last;
            b_tag_reg        <= a_tag_reg;
            b_tag_reg.emit   <= a_valid_reg && a_tag_reg.emit;
            c_tag_reg        <= b_tag_reg;
            d_tag_reg        <= c_tag_reg;
            e_tag_reg        <= d_tag_reg;
        end
    end

    // line memory: read on request, write back in the following cycle
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rd_reg    <= line_mem[col_reg];
            a_col_reg <= col_reg;
            a_pix_reg <= pix_in;
        end
        if (a_valid_reg)
        begin
            line_mem[a_col_reg] <= '{older: rd_reg.newer, newer: a_pix_reg};
        end
    end

    // window shift and center delay line
    always_ff @(posedge clk)
    begin
        if (a_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= rd_reg.older;
            win_reg[1][2] <= rd_reg.newer;
            win_reg[2][2] <= a_pix_reg;
        end
        c_center_reg <= win_reg[1][1];
        d_center_reg <= c_center_reg;
        e_center_reg <= d_center_reg;
    end

    assign rows = {k_below_reg, k_center_reg, k_above_reg};

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                kernel[3*r+c]    = rows[r][WEIGHT_W*c +: WEIGHT_W];
                win_red[3*r+c]   = win_reg[r][c].red;
                win_green[3*r+c] = win_reg[r][c].green;
                win_blue[3*r+c]  = win_reg[r][c].blue;
            end
        end
    end

    rgbc_filter u_filt_red (
        .clk       (clk),
        .win       (win_red),
        .kernel    (kernel),
        .offset_en (offset_en_reg),
        .result    (filt_red)
    );

    rgbc_filter u_filt_green (
        .clk       (clk),
        .win       (win_green),
        .kernel    (kernel),
        .offset_en (offset_en_reg),
        .result    (filt_green)
    );

    rgbc_filter u_filt_blue (
        .clk       (clk),
        .win       (win_blue),
        .kernel    (kernel),
        .offset_en (offset_en_reg),
        .result    (filt_blue)
    );

    // output queue
    assign push           = e_tag_reg.emit;
    assign push_item.pix  = e_tag_reg.inner ? {filt_red, filt_green, filt_blue} : e_center_reg;
    assign push_item.last = e_tag_reg.last;
    assign out_valid      = fifo_cnt_reg != '0;
    assign pop            = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[fifo_tail_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_head_reg <= '0;
            fifo_tail_reg <= '0;
            fifo_cnt_reg  <= '0;
            pending_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                fifo_tail_reg <= fifo_tail_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                fifo_head_reg <= fifo_head_reg + FIFO_AW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + FIFO_CW'(push) - FIFO_CW'(pop);
            pending_reg  <= pending_reg + FIFO_CW'(credit) - FIFO_CW'(pop);
        end
    end

    assign out_red    = fifo_mem[fifo_head_reg].pix.red;
    assign out_green  = fifo_mem[fifo_head_reg].pix.green;
    assign out_blue   = fifo_mem[fifo_head_reg].pix.blue;
    assign frame_last = fifo_mem[fifo_head_reg].last;

    // checks
    a_queue_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= pending_reg)
        else $error("output queue holds more results than were credited");

    a_credit_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("results in flight exceed queue depth");

    a_no_request_during_div: assert property (@(posedge clk) disable iff (!rst_n)
        (div_st.busy || div_st.done) |-> !take)
        else $error("request taken while output position is recomputed");

endmodule

// File: tb/rgb_conv3x3_filter_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for rgb_conv3x3_filter_unit: random and corner frames, predicted outputs.
// Depends on rgbc_pkg and the rgb_conv3x3_filter_unit RTL.
module rgb_conv3x3_filter_unit_tb;
    import rgbc_pkg::*;

    localparam int LINE_MAX       = 2048;
    localparam int SETTLE_CYCLES  = 30;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 640;
    localparam logic [2:0] IDX_SPARE_LOW  = 3'd6;
    localparam logic [2:0] IDX_SPARE_HIGH = 3'd7;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 18'h1FFFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 18'h20000;

    logic                clk;
    logic                rst_n;
    logic                cfg_write;
    logic [2:0]          cfg_index;
    logic [KERNEL_W-1:0] cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic                operation;
    logic [PIX_W-1:0]    in_red;
    logic [PIX_W-1:0]    in_green;
    logic [PIX_W-1:0]    in_blue;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [PIX_W-1:0]    out_red;
    logic [PIX_W-1:0]    out_green;
    logic [PIX_W-1:0]    out_blue;
    logic                frame_last;

    // mirror of the block's registers and pipeline state
    logic [KERNEL_W-1:0] kern_rows [3];
    logic                offset_on;
    logic [CFG_W-1:0]    width_reg;
    logic [CFG_W-1:0]    height_reg;
    pix_t                older_line [LINE_MAX];
    pix_t                newer_line [LINE_MAX];
    pix_t                win [3][3];
    int unsigned         col_pos;
    int unsigned         row_pos;
    int unsigned         out_pos;
    int unsigned         entered_count;
    int unsigned         items_taken;
    bit                  frame_closed;

    out_item_t           filtered_q [$];
    out_item_t           want_pix;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  fail_count;
    int                  stuck_cycles;

    rgb_conv3x3_filter_unit #(
        .MAX_WIDTH (LINE_MAX)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .in_red     (in_red),
        .in_green   (in_green),
        .in_blue    (in_blue),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .frame_last (frame_last)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int unsigned active_width();
        int unsigned w;
        w = width_reg;
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > LINE_MAX) w = LINE_MAX;
        return w;
    endfunction

    function automatic int unsigned active_height();
        int unsigned h;
        h = height_reg;
        if (h < MIN_DIM) h = MIN_DIM;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic logic [PIX_W-1:0] filter_chan(input int ch);
        longint             acc;
        longint             q;
        logic signed [WEIGHT_W-1:0] wt;
        logic [PIX_W-1:0]   p;
        acc = 0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                wt = kern_rows[r][WEIGHT_W*c +: WEIGHT_W];
                p = win[r][c][PIX_W*(2-ch) +: PIX_W];
                acc += longint'(wt) * longint'(p);
            end
        end
        q = acc / (longint'(1) << COEFF_FRAC_BITS);
        if (offset_on) q += OFFSET_VALUE;
        if (q < 0) q = 0;
        if (q > PIX_MAX) q = PIX_MAX;
        return q[PIX_W-1:0];
    endfunction

    // shift one request into the window; returns 1 when it releases an output pixel
    function automatic bit advance_window(input logic op, input pix_t px, output out_item_t res);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned orow;
        int unsigned ocol;
        bit          primed;
        pix_t        entering;
        w = active_width();
        h = active_height();
        res = '0;
        primed = (row_pos >= 2) || (row_pos == 1 && col_pos >= 1);
        if (op == OP_DRAIN && !primed) return 0;
        entering = px;
        if (op == OP_DRAIN) entering = '0;
        c = (col_pos < LINE_MAX) ? col_pos : LINE_MAX - 1;
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = older_line[c];
        win[1][2] = newer_line[c];
        win[2][2] = entering;
        older_line[c] = newer_line[c];
        newer_line[c] = entering;
        items_taken++;
        entered_count++;
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            if (row_pos < ROW_MAX) row_pos++;
        end
        else
        begin
            col_pos++;
        end
        if (!primed) return 0;
        orow = out_pos / w;
        ocol = out_pos % w;
        if (orow >= 1 && orow <= h - 2 && ocol >= 1 && ocol <= w - 2)
        begin
            res.pix.red   = filter_chan(0);
            res.pix.green = filter_chan(1);
            res.pix.blue  = filter_chan(2);
        end
        else
        begin
            res.pix = win[1][1];
        end
        res.last = (out_pos + 1 >= w * h);
        if (res.last)
        begin
            col_pos = 0;
            row_pos = 0;
            out_pos = 0;
            entered_count = 0;
            frame_closed = 1'b1;
        end
        else
        begin
            out_pos++;
        end
        return 1;
    endfunction

    function automatic pix_t random_pixel();
        pix_t px;
        for (int b = 0; b < 3; b++)
        begin
            if ($urandom_range(7) == 0)
                px[PIX_W*b +: PIX_W] = $urandom_range(1) ? 8'hFF : 8'h00;
            else
                px[PIX_W*b +: PIX_W] = PIX_W'($urandom_range(PIX_MAX));
        end
        return px;
    endfunction

    function automatic logic [KERNEL_W-1:0] random_kernel_row();
        logic [KERNEL_W-1:0] row;
        int                  v;
        for (int k = 0; k < 3; k++)
        begin
            case ($urandom_range(9))
                0: row[WEIGHT_W*k +: WEIGHT_W] = WEIGHT_MIN;
                1: row[WEIGHT_W*k +: WEIGHT_W] = WEIGHT_MAX;
                2: row[WEIGHT_W*k +: WEIGHT_W] = '0;
                default:
                begin
                    v = int'($urandom_range(64)) - 32;
                    row[WEIGHT_W*k +: WEIGHT_W] = v[WEIGHT_W-1:0];
                end
            endcase
        end
        return row;
    endfunction

    // field in the low bits, either zeros or noise above it
    function automatic logic [KERNEL_W-1:0] padded_word(input logic [CFG_W-1:0] field,
                                                        input int field_bits);
        logic [KERNEL_W-1:0] word;
        word = '0;
        if ($urandom_range(1)) word = KERNEL_W'({$urandom, $urandom});
        for (int b = 0; b < field_bits; b++) word[b] = field[b];
        return word;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic write_register(input logic [2:0] idx, input logic [KERNEL_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_KERNEL_ABOVE:  kern_rows[0] = value;
            REG_KERNEL_CENTER: kern_rows[1] = value;
            REG_KERNEL_BELOW:  kern_rows[2] = value;
            REG_OFFSET_ENABLE: offset_on = value[0];
            REG_IMAGE_WIDTH:   width_reg = value[CFG_W-1:0];
            REG_IMAGE_HEIGHT:  height_reg = value[CFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic push_request(input logic op, input pix_t px);
        int        gap;
        bit        got;
        out_item_t res;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        in_red    <= px.red;
        in_green  <= px.green;
        in_blue   <= px.blue;
        do @(posedge clk); while (in_stall);
        got = advance_window(op, px, res);
        if (got) filtered_q.push_back(res);
    endtask

    // hold requests until every predicted pixel is out, then let the pipe settle
    task automatic await_quiet(input int settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic send_frame(input int drain_pct, input int pause_item);
        int   n;
        logic op;
        n = 0;
        frame_closed = 1'b0;
        while (!frame_closed)
        begin
            if (entered_count >= active_width() * active_height())
                op = ($urandom_range(99) < 75) ? OP_DRAIN : OP_PIXEL;
            else
                op = ($urandom_range(99) < drain_pct) ? OP_DRAIN : OP_PIXEL;
            push_request(op, random_pixel());
            n++;
            if (n == pause_item) await_quiet(0);
        end
    endtask

    task automatic randomize_setup();
        int unsigned w;
        int unsigned h;
        await_quiet(SETTLE_CYCLES);
        if ($urandom_range(1)) write_register(REG_KERNEL_ABOVE, random_kernel_row());
        if ($urandom_range(1)) write_register(REG_KERNEL_CENTER, random_kernel_row());
        if ($urandom_range(1)) write_register(REG_KERNEL_BELOW, random_kernel_row());
        if ($urandom_range(2) == 0)
            write_register(REG_OFFSET_ENABLE, padded_word(CFG_W'($urandom_range(1)), 1));
        if ($urandom_range(9) == 0)
            write_register($urandom_range(1) ? IDX_SPARE_LOW : IDX_SPARE_HIGH,
                           KERNEL_W'({$urandom, $urandom}));
        case ($urandom_range(9))
            0:       w = $urandom_range(2);
            1:       w = $urandom_range(13, 40);
            default: w = $urandom_range(MIN_DIM, 12);
        endcase
        h = ($urandom_range(6) == 0) ? $urandom_range(2) : $urandom_range(MIN_DIM, 6);
        if ($urandom_range(4) != 0) write_register(REG_IMAGE_WIDTH, padded_word(w, CFG_W));
        if ($urandom_range(4) != 0) write_register(REG_IMAGE_HEIGHT, padded_word(h, CFG_W));
    endtask

    task automatic test_register_setup();
        write_register(REG_KERNEL_ABOVE, {3{WEIGHT_MAX}});
        write_register(REG_KERNEL_CENTER, {3{WEIGHT_MAX}});
        write_register(REG_KERNEL_BELOW, {3{WEIGHT_MAX}});
        write_register(REG_OFFSET_ENABLE, '0);
        write_register(REG_IMAGE_WIDTH, MIN_DIM);
        write_register(REG_IMAGE_HEIGHT, MIN_DIM);
        write_register(IDX_SPARE_LOW, '1);
        write_register(IDX_SPARE_HIGH, '1);
    endtask

    // full-scale weights of both signs on 3x3 frames: clamp high, clamp low, offset on black
    task automatic test_saturating_kernels();
        pix_t px;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_request(OP_DRAIN, '1);
        for (int i = 0; i < 9; i++)
        begin
            px.red   = (i % 2) ? 8'hFF : 8'h00;
            px.green = (i % 3 == 0) ? 8'hFF : 8'h00;
            px.blue  = (i == 4) ? 8'hFF : 8'h00;
            push_request(OP_PIXEL, px);
        end
        push_request(OP_DRAIN, '0);
        push_request(OP_PIXEL, '1);
        push_request(OP_DRAIN, '1);
        push_request(OP_PIXEL, '0);
        await_quiet(SETTLE_CYCLES);
        write_register(REG_KERNEL_ABOVE, {3{WEIGHT_MIN}});
        write_register(REG_KERNEL_CENTER, {3{WEIGHT_MIN}});
        write_register(REG_KERNEL_BELOW, {3{WEIGHT_MIN}});
        write_register(REG_OFFSET_ENABLE, 54'h1);
        for (int i = 0; i < 9; i++)
        begin
            if (i == 2) push_request(OP_DRAIN, '0);
            px.red   = 8'(255 - 16 * i);
            px.green = 8'(30 * i);
            px.blue  = 8'h00;
            push_request(OP_PIXEL, px);
        end
        repeat (4) push_request(OP_DRAIN, random_pixel());
    endtask

    task automatic test_random_frames(input int send_pct, input int recv_pct,
                                      input bit with_pause);
        int unsigned start;
        bit          pause_pending;
        start = items_taken;
        pause_pending = with_pause;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (items_taken - start < PHASE_ITEMS)
        begin
            randomize_setup();
            send_frame(3, pause_pending ? 10 : 0);
            pause_pending = 1'b0;
        end
    endtask

    // out-of-range sizes: widest line with fewest rows, tallest frame with narrowest line
    task automatic test_clamped_sizes();
        send_idle_pct = 5;
        recv_idle_pct = 5;
        await_quiet(SETTLE_CYCLES);
        write_register(REG_KERNEL_ABOVE, random_kernel_row());
        write_register(REG_KERNEL_CENTER, random_kernel_row());
        write_register(REG_KERNEL_BELOW, random_kernel_row());
        write_register(REG_IMAGE_WIDTH, padded_word('1, CFG_W));
        write_register(REG_IMAGE_HEIGHT, padded_word('0, CFG_W));
        send_frame(1, 0);
        await_quiet(SETTLE_CYCLES);
        write_register(REG_IMAGE_WIDTH, padded_word('0, CFG_W));
        write_register(REG_IMAGE_HEIGHT, padded_word('1, CFG_W));
        send_frame(1, 0);
    endtask

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (filtered_q.size() == 0)
            begin
                $error("output pixel with no request pending");
                fail_count++;
            end
            else
            begin
                want_pix = filtered_q.pop_front();
                check_field("out_red", want_pix.pix.red, out_red);
                check_field("out_green", want_pix.pix.green, out_green);
                check_field("out_blue", want_pix.pix.blue, out_blue);
                check_field("frame_last", want_pix.last, frame_last);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        operation     = OP_PIXEL;
        in_red        = '0;
        in_green      = '0;
        in_blue       = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fail_count    = 0;
        stuck_cycles  = 0;
        kern_rows[0]  = '0;
        kern_rows[1]  = 54'd16777216;
        kern_rows[2]  = '0;
        offset_on     = 1'b0;
        width_reg     = 12'd640;
        height_reg    = 12'd480;
        for (int i = 0; i < LINE_MAX; i++)
        begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++) win[r][c] = '0;
        end
        col_pos       = 0;
        row_pos       = 0;
        out_pos       = 0;
        entered_count = 0;
        items_taken   = 0;
        frame_closed  = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_register_setup();
        test_saturating_kernels();
        test_random_frames(22, 52, 1'b1);
        test_random_frames(52, 22, 1'b0);
        test_random_frames(0, 0, 1'b0);
        test_clamped_sizes();

        await_quiet(SETTLE_CYCLES);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
